// ===== rtl/mrq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrq_pkg
// Shared widths, codes, microcode step addresses and control types for the
// length-prefixed message ring queue.
// ----------------------------------------------------------------------------
package mrq_pkg;

	localparam int DEF_BUFFER_BYTES = 64;
	localparam int MAX_MSG_BYTES    = 16;

	localparam int MODE_W   = 2;
	localparam int MSG_W    = 64;
	localparam int LEN_W    = 5;
	localparam int STATUS_W = 3;
	localparam int BYTE_W   = 8;
	localparam int CNT_W    = 4;          // byte index within a message
	localparam int OFS_W    = LEN_W + 1;  // pointer offsets up to length + 1

	// request modes
	localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// result status
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OK_FLUSHED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_LENGTH = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BAD_STORED = 3'd5;

	// datapath operations
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
	localparam logic [OP_W-1:0] OP_FLUSH    = 4'd1;
	localparam logic [OP_W-1:0] OP_WR_DATA  = 4'd2;
	localparam logic [OP_W-1:0] OP_WR_LEN   = 4'd3;
	localparam logic [OP_W-1:0] OP_RD_LEN   = 4'd4;
	localparam logic [OP_W-1:0] OP_RD_FIRST = 4'd5;
	localparam logic [OP_W-1:0] OP_RD_DATA  = 4'd6;
	localparam logic [OP_W-1:0] OP_POP_DONE = 4'd7;
	localparam logic [OP_W-1:0] OP_CLEAR    = 4'd8;
	localparam logic [OP_W-1:0] OP_EMIT     = 4'd9;

	// jump conditions
	localparam int COND_W = 4;
	localparam logic [COND_W-1:0] C_NONE      = 4'd0;
	localparam logic [COND_W-1:0] C_ALWAYS    = 4'd1;
	localparam logic [COND_W-1:0] C_DISPATCH  = 4'd2;
	localparam logic [COND_W-1:0] C_BADLEN    = 4'd3;
	localparam logic [COND_W-1:0] C_FITS      = 4'd4;
	localparam logic [COND_W-1:0] C_NOFIT     = 4'd5;
	localparam logic [COND_W-1:0] C_EMPTY     = 4'd6;
	localparam logic [COND_W-1:0] C_BADSTORED = 4'd7;
	localparam logic [COND_W-1:0] C_MORE      = 4'd8;
	localparam logic [COND_W-1:0] C_HOLD_OUT  = 4'd9;

	// microprogram addresses
	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] STEP_IDLE    = 5'd0;
	localparam logic [PC_W-1:0] STEP_P_CHK   = 5'd1;
	localparam logic [PC_W-1:0] STEP_P_FIT   = 5'd2;
	localparam logic [PC_W-1:0] STEP_P_FLUSH = 5'd3;
	localparam logic [PC_W-1:0] STEP_P_REFIT = 5'd4;
	localparam logic [PC_W-1:0] STEP_P_WR    = 5'd5;
	localparam logic [PC_W-1:0] STEP_P_LEN   = 5'd6;
	localparam logic [PC_W-1:0] STEP_Q_CHK   = 5'd7;
	localparam logic [PC_W-1:0] STEP_Q_LEN   = 5'd8;
	localparam logic [PC_W-1:0] STEP_Q_DATA  = 5'd9;
	localparam logic [PC_W-1:0] STEP_Q_DONE  = 5'd10;
	localparam logic [PC_W-1:0] STEP_EMIT    = 5'd11;
	localparam logic [PC_W-1:0] STEP_CLR     = 5'd12;
	localparam logic [PC_W-1:0] STEP_NOP     = 5'd13;
	localparam logic [PC_W-1:0] STEP_S_BADLEN = 5'd14;
	localparam logic [PC_W-1:0] STEP_S_OVF    = 5'd15;
	localparam logic [PC_W-1:0] STEP_S_EMPTY  = 5'd16;
	localparam logic [PC_W-1:0] STEP_S_BADST  = 5'd17;
	localparam logic [PC_W-1:0] STEP_LAST     = 5'd17;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [COND_W-1:0]   cond;
		logic [PC_W-1:0]     target;
		logic                st_we;
		logic [STATUS_W-1:0] st;
	} ctrl_t;

	typedef struct packed {
		logic bad_len;
		logic fits;
		logic empty;
		logic bad_stored;
		logic more;
		logic out_busy;
	} cond_t;

endpackage
`default_nettype wire

// ===== rtl/mrq_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrq_if
// Valid/ready channels of the message ring queue: request and result.
// ----------------------------------------------------------------------------
interface mrq_in_if;
	import mrq_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [MSG_W-1:0]  msg_low;
	logic [MSG_W-1:0]  msg_high;
	logic [LEN_W-1:0]  msg_length;

	modport source (output valid, mode, msg_low, msg_high, msg_length, input ready);
	modport sink   (input valid, mode, msg_low, msg_high, msg_length, output ready);
endinterface

interface mrq_out_if;
	import mrq_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [MSG_W-1:0]    out_low;
	logic [MSG_W-1:0]    out_high;
	logic [LEN_W-1:0]    out_length;

	modport source (output valid, status, out_low, out_high, out_length, input ready);
	modport sink   (input valid, status, out_low, out_high, out_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/mrq_ucode_rom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrq_ucode_rom
// Control store: one control word per microprogram step.
// ----------------------------------------------------------------------------
module mrq_ucode_rom (
	input  logic [mrq_pkg::PC_W-1:0] pc,
	output mrq_pkg::ctrl_t           ctrl
);
	import mrq_pkg::*;

	function automatic ctrl_t word(input logic [OP_W-1:0] op,
			input logic [COND_W-1:0] cond, input logic [PC_W-1:0] target,
			input logic st_we, input logic [STATUS_W-1:0] st);
		ctrl_t w;
		w.op     = op;
		w.cond   = cond;
		w.target = target;
		w.st_we  = st_we;
		w.st     = st;
		return w;
	endfunction

	always_comb begin
		case (pc)
			STEP_IDLE:     ctrl = word(OP_NONE, C_DISPATCH, STEP_IDLE, 1'b0, ST_OK);
			// push
			STEP_P_CHK:    ctrl = word(OP_NONE, C_BADLEN, STEP_S_BADLEN, 1'b0, ST_OK);
			STEP_P_FIT:    ctrl = word(OP_NONE, C_FITS, STEP_P_WR, 1'b0, ST_OK);
			STEP_P_FLUSH:  ctrl = word(OP_FLUSH, C_NONE, STEP_IDLE, 1'b1, ST_OK_FLUSHED);
			STEP_P_REFIT:  ctrl = word(OP_NONE, C_NOFIT, STEP_S_OVF, 1'b0, ST_OK);
			STEP_P_WR:     ctrl = word(OP_WR_DATA, C_MORE, STEP_P_WR, 1'b0, ST_OK);
			STEP_P_LEN:    ctrl = word(OP_WR_LEN, C_ALWAYS, STEP_EMIT, 1'b0, ST_OK);
			// pop
			STEP_Q_CHK:    ctrl = word(OP_RD_LEN, C_EMPTY, STEP_S_EMPTY, 1'b0, ST_OK);
			STEP_Q_LEN:    ctrl = word(OP_RD_FIRST, C_BADSTORED, STEP_S_BADST, 1'b0, ST_OK);
			STEP_Q_DATA:   ctrl = word(OP_RD_DATA, C_MORE, STEP_Q_DATA, 1'b0, ST_OK);
			STEP_Q_DONE:   ctrl = word(OP_POP_DONE, C_NONE, STEP_IDLE, 1'b0, ST_OK);
			// result out, waits for a free output register
			STEP_EMIT:     ctrl = word(OP_EMIT, C_HOLD_OUT, STEP_IDLE, 1'b0, ST_OK);
			STEP_CLR:      ctrl = word(OP_CLEAR, C_ALWAYS, STEP_EMIT, 1'b0, ST_OK);
			STEP_NOP:      ctrl = word(OP_NONE, C_ALWAYS, STEP_EMIT, 1'b0, ST_OK);
			STEP_S_BADLEN: ctrl = word(OP_NONE, C_ALWAYS, STEP_EMIT, 1'b1, ST_BAD_LENGTH);
			STEP_S_OVF:    ctrl = word(OP_NONE, C_ALWAYS, STEP_EMIT, 1'b1, ST_OVERFLOW);
			STEP_S_EMPTY:  ctrl = word(OP_NONE, C_ALWAYS, STEP_EMIT, 1'b1, ST_EMPTY);
			STEP_S_BADST:  ctrl = word(OP_NONE, C_ALWAYS, STEP_EMIT, 1'b1, ST_BAD_STORED);
			default:       ctrl = word(OP_NONE, C_ALWAYS, STEP_IDLE, 1'b0, ST_OK);
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/mrq_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrq_sequencer
// Step counter with conditional jumps and mode dispatch over the control store.
// ----------------------------------------------------------------------------
module mrq_sequencer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic [mrq_pkg::MODE_W-1:0] mode,
	input  mrq_pkg::cond_t             flags,
	output mrq_pkg::ctrl_t             ctrl,
	output logic                       idle,
	output logic                       accept
);
	import mrq_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_inc;
	logic [PC_W-1:0] pc_next;
	logic [PC_W-1:0] dispatch;

	mrq_ucode_rom u_rom (
		.pc   (pc_q),
		.ctrl (ctrl)
	);

	assign idle   = (pc_q == STEP_IDLE);
	assign accept = idle && req_valid;
	assign pc_inc = pc_q + PC_W'(1);

	always_comb begin
		case (mode)
			MODE_PUSH:  dispatch = STEP_P_CHK;
			MODE_POP:   dispatch = STEP_Q_CHK;
			MODE_CLEAR: dispatch = STEP_CLR;
			default:    dispatch = STEP_NOP;
		endcase
	end

	always_comb begin
		case (ctrl.cond)
			C_NONE:      pc_next = pc_inc;
			C_ALWAYS:    pc_next = ctrl.target;
			C_DISPATCH:  pc_next = accept ? dispatch : pc_q;
			C_BADLEN:    pc_next = flags.bad_len ? ctrl.target : pc_inc;
			C_FITS:      pc_next = flags.fits ? ctrl.target : pc_inc;
			C_NOFIT:     pc_next = flags.fits ? pc_inc : ctrl.target;
			C_EMPTY:     pc_next = flags.empty ? ctrl.target : pc_inc;
			C_BADSTORED: pc_next = flags.bad_stored ? ctrl.target : pc_inc;
			C_MORE:      pc_next = flags.more ? ctrl.target : pc_inc;
			C_HOLD_OUT:  pc_next = flags.out_busy ? pc_q : ctrl.target;
			default:     pc_next = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mrq_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrq_datapath
// Byte ring memory, read/write pointers, byte counter, message registers and
// the result register, driven by the control word of the current step.
// ----------------------------------------------------------------------------
module mrq_datapath #(
	parameter int BUFFER_BYTES = mrq_pkg::DEF_BUFFER_BYTES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mrq_pkg::ctrl_t            ctrl,
	input  logic                      accept,
	input  logic [mrq_pkg::MSG_W-1:0] msg_low,
	input  logic [mrq_pkg::MSG_W-1:0] msg_high,
	input  logic [mrq_pkg::LEN_W-1:0] msg_length,
	output mrq_pkg::cond_t            flags,
	mrq_out_if.source                 rsp
);
	import mrq_pkg::*;

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int SW = AW + 1;
	localparam logic [SW-1:0] RING_N = SW'(BUFFER_BYTES);

	// pointer + offset, wrapped once (offset never reaches the ring size)
	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p,
			input logic [OFS_W-1:0] k);
		logic [SW-1:0] s;
		s = {1'b0, p} + SW'(k);
		if (s >= RING_N)
			s = s - RING_N;
		return s[AW-1:0];
	endfunction

	logic [BYTE_W-1:0]   mem [BUFFER_BYTES];
	logic [BYTE_W-1:0]   rdata_q;
	logic [AW-1:0]       rp_q;
	logic [AW-1:0]       wp_q;
	logic [LEN_W-1:0]    len_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [2*MSG_W-1:0]  msg_q;
	logic [2*MSG_W-1:0]  data_q;
	logic                pop_ok_q;
	logic [STATUS_W-1:0] status_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [MSG_W-1:0]    out_low_q;
	logic [MSG_W-1:0]    out_high_q;
	logic [LEN_W-1:0]    out_length_q;

	logic                mem_we;
	logic                mem_re;
	logic [AW-1:0]       waddr;
	logic [AW-1:0]       raddr;
	logic [BYTE_W-1:0]   wdata;
	logic [SW-1:0]       room;
	logic [SW-1:0]       need;
	logic [OFS_W-1:0]    len_step;
	logic                emit_fire;

	assign len_step  = OFS_W'(len_q) + OFS_W'(1);
	assign emit_fire = (ctrl.op == OP_EMIT) && !flags.out_busy;

	// room check: free run from the write pointer to the read pointer, an
	// empty ring counts as the whole ring
	always_comb begin
		if (rp_q > wp_q)
			room = {1'b0, rp_q} - {1'b0, wp_q};
		else
			room = {1'b0, rp_q} + RING_N - {1'b0, wp_q};
		need = SW'(len_step);
	end

	always_comb begin
		flags.bad_len    = (len_q == '0) || (len_q > LEN_W'(MAX_MSG_BYTES));
		flags.fits       = room > need;
		flags.empty      = (rp_q == wp_q);
		flags.bad_stored = (rdata_q == '0) || (rdata_q > BYTE_W'(MAX_MSG_BYTES));
		flags.more       = {1'b0, cnt_q} != (len_q - LEN_W'(1));
		flags.out_busy   = out_valid_q && !rsp.ready;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		waddr  = wp_q;
		raddr  = rp_q;
		wdata  = msg_q[{cnt_q, 3'b000} +: BYTE_W];
		case (ctrl.op)
			OP_WR_DATA: begin
				mem_we = 1'b1;
				waddr  = ring_add(wp_q, OFS_W'(cnt_q) + OFS_W'(1));
			end
			OP_WR_LEN: begin
				mem_we = 1'b1;
				wdata  = BYTE_W'(len_q);
			end
			OP_RD_LEN: begin
				mem_re = 1'b1;
			end
			OP_RD_FIRST: begin
				mem_re = 1'b1;
				raddr  = ring_add(rp_q, OFS_W'(1));
			end
			OP_RD_DATA: begin
				// fetch one ahead; the last fetch lands past the message, unused
				mem_re = 1'b1;
				raddr  = ring_add(rp_q, OFS_W'(cnt_q) + OFS_W'(2));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		if (mem_re)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			wp_q <= '0;
		end else begin
			case (ctrl.op)
				OP_FLUSH, OP_CLEAR: begin
					rp_q <= '0;
					wp_q <= '0;
				end
				OP_WR_LEN:   wp_q <= ring_add(wp_q, len_step);
				OP_POP_DONE: rp_q <= ring_add(rp_q, len_step);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			len_q    <= msg_length;
			msg_q    <= {msg_high, msg_low};
			data_q   <= '0;
			cnt_q    <= '0;
			pop_ok_q <= 1'b0;
			status_q <= ST_OK;
		end else begin
			if (ctrl.st_we)
				status_q <= ctrl.st;
			case (ctrl.op)
				OP_WR_DATA: cnt_q <= cnt_q + CNT_W'(1);
				OP_RD_FIRST: begin
					len_q <= rdata_q[LEN_W-1:0];
					cnt_q <= '0;
				end
				OP_RD_DATA: begin
					data_q[{cnt_q, 3'b000} +: BYTE_W] <= rdata_q;
					cnt_q <= cnt_q + CNT_W'(1);
				end
				OP_POP_DONE: pop_ok_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_status_q <= status_q;
			out_low_q    <= data_q[MSG_W-1:0];
			out_high_q   <= data_q[2*MSG_W-1:MSG_W];
			out_length_q <= pop_ok_q ? len_q : '0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.out_low    = out_low_q;
	assign rsp.out_high   = out_high_q;
	assign rsp.out_length = out_length_q;

`ifndef NO_ASSERTIONS
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, rp_q} < RING_N) && ({1'b0, wp_q} < RING_N))
		else $error("ring pointer out of range");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_FLUSH) |=> (rp_q == '0) && (wp_q == '0) && flags.fits)
		else $error("flush left queue non-empty or without room");

	a_data_len_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_WR_DATA || ctrl.op == OP_RD_DATA) |->
		(len_q != '0) && (len_q <= LEN_W'(MAX_MSG_BYTES)))
		else $error("byte loop with bad message length");

	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.out_length != '0) |-> (rsp.status == ST_OK))
		else $error("popped data with failing status");
`endif

endmodule
`default_nettype wire

// ===== rtl/message_ring_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// message_ring_queue
// Byte ring queue of length-prefixed messages, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Each request is handled to completion by a small microprogram over a
// byte-wide ring memory with one write and one read port, so every message
// byte takes its own microprogram step. A push that does not fit flushes
// the queue and is retried once. The next request is taken as soon as the
// result sits in the output register, even if it has not been taken yet;
// the block only stalls when a second result is ready while the first
// still waits. No clearing pass after reset.
module message_ring_queue #(
	parameter int BUFFER_BYTES = mrq_pkg::DEF_BUFFER_BYTES
) (
	input  logic      clk,
	input  logic      arst_n,
	mrq_in_if.sink    req,
	mrq_out_if.source rsp
);
	import mrq_pkg::*;

	ctrl_t ctrl;
	cond_t flags;
	logic  idle;
	logic  accept;

	assign req.ready = idle;

	mrq_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.mode      (req.mode),
		.flags     (flags),
		.ctrl      (ctrl),
		.idle      (idle),
		.accept    (accept)
	);

	mrq_datapath #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.accept     (accept),
		.msg_low    (req.msg_low),
		.msg_high   (req.msg_high),
		.msg_length (req.msg_length),
		.flags      (flags),
		.rsp        (rsp)
	);

endmodule
`default_nettype wire

// ===== dv/tb_message_ring_queue.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_message_ring_queue
// Checks the message ring queue against a byte-level shadow of the ring. A
// directed opening covers bad lengths, empty pops, the extreme message sizes,
// clear, the unused mode and flush-on-overflow. Random phases then lean
// toward filling, draining or neither, so the ring wraps, flushes and
// runs empty. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_message_ring_queue;
	import mrq_pkg::*;

	localparam int RING_BYTES = DEF_BUFFER_BYTES;
	localparam int RANDOM_REQS = 400;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		bit                drain;  // marker: hold off until every result is back
		logic [MODE_W-1:0] mode;
		logic [MSG_W-1:0]  msg_low;
		logic [MSG_W-1:0]  msg_high;
		logic [LEN_W-1:0]  msg_length;
	} queue_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [MSG_W-1:0]    out_low;
		logic [MSG_W-1:0]    out_high;
		logic [LEN_W-1:0]    out_length;
	} queue_result_t;

	logic clk = 1'b0;
	logic arst_n;

	mrq_in_if  req();
	mrq_out_if rsp();

	message_ring_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow of the ring and its pointers
	logic [BYTE_W-1:0] ring_shadow [RING_BYTES];
	int rd_ptr = 0;
	int wr_ptr = 0;

	queue_req_t    queued_requests[$];
	queue_result_t pending_results[$];
	queue_req_t    driven_req;

	int mismatches = 0;
	int n_requests = 0;
	int n_stored = 0, n_flushed = 0, n_dropped = 0, n_bad_len = 0;
	int n_popped = 0, n_empty = 0, n_bad_stored = 0, n_clears = 0, n_unused = 0;

	// One write attempt from the write pointer; commits only if the message
	// and the next length slot stay clear of the read pointer.
	function automatic bit store_message(logic [2*MSG_W-1:0] msg, int len);
		int pos;
		pos = wr_ptr;
		ring_shadow[pos] = '0;
		pos = (pos + 1) % RING_BYTES;
		for (int i = 0; i < len; i++) begin
			if (pos == rd_ptr)
				return 1'b0;
			ring_shadow[pos] = msg[8*i +: 8];
			pos = (pos + 1) % RING_BYTES;
		end
		if (pos == rd_ptr)
			return 1'b0;
		ring_shadow[wr_ptr] = BYTE_W'(len);
		wr_ptr = pos;
		return 1'b1;
	endfunction

	function automatic queue_result_t apply_request(queue_req_t rq);
		queue_result_t res;
		logic [2*MSG_W-1:0] popped;
		int pos;
		int n;
		res = '0;
		res.status = ST_OK;
		case (rq.mode)
			MODE_PUSH: begin
				if (rq.msg_length == 0 || rq.msg_length > MAX_MSG_BYTES) begin
					res.status = ST_BAD_LENGTH;
					n_bad_len++;
				end else if (store_message({rq.msg_high, rq.msg_low},
						int'(rq.msg_length))) begin
					n_stored++;
				end else begin
					// newest message wins: flush and retry once
					rd_ptr = 0;
					wr_ptr = 0;
					if (store_message({rq.msg_high, rq.msg_low},
							int'(rq.msg_length))) begin
						res.status = ST_OK_FLUSHED;
						n_flushed++;
					end else begin
						res.status = ST_OVERFLOW;
						n_dropped++;
					end
				end
			end
			MODE_POP: begin
				if (rd_ptr == wr_ptr) begin
					res.status = ST_EMPTY;
					n_empty++;
				end else begin
					n = int'(ring_shadow[rd_ptr]);
					if (n == 0 || n > MAX_MSG_BYTES) begin
						res.status = ST_BAD_STORED;
						n_bad_stored++;
					end else begin
						popped = '0;
						pos = (rd_ptr + 1) % RING_BYTES;
						for (int i = 0; i < n; i++) begin
							popped[8*i +: 8] = ring_shadow[pos];
							pos = (pos + 1) % RING_BYTES;
						end
						rd_ptr = pos;
						res.out_low = popped[MSG_W-1:0];
						res.out_high = popped[2*MSG_W-1:MSG_W];
						res.out_length = LEN_W'(n);
						n_popped++;
					end
				end
			end
			MODE_CLEAR: begin
				for (int i = 0; i < RING_BYTES; i++)
					ring_shadow[i] = '0;
				rd_ptr = 0;
				wr_ptr = 0;
				n_clears++;
			end
			default: n_unused++;
		endcase
		return res;
	endfunction

	function automatic logic [MSG_W-1:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	function automatic void add_request(logic [MODE_W-1:0] mode, logic [MSG_W-1:0] lo,
			logic [MSG_W-1:0] hi, logic [LEN_W-1:0] len);
		queue_req_t rq;
		rq.drain = 1'b0;
		rq.mode = mode;
		rq.msg_low = lo;
		rq.msg_high = hi;
		rq.msg_length = len;
		queued_requests.push_back(rq);
	endfunction

	function automatic void add_drain();
		queue_req_t rq;
		rq = '0;
		rq.drain = 1'b1;
		queued_requests.push_back(rq);
	endfunction

	function automatic logic [LEN_W-1:0] rand_push_length();
		case ($urandom_range(0, 9))
			0: return ($urandom_range(0, 1) == 0) ? LEN_W'(0) : LEN_W'($urandom_range(17, 31));
			1, 2: return LEN_W'(MAX_MSG_BYTES);
			default: return LEN_W'($urandom_range(1, MAX_MSG_BYTES - 1));
		endcase
	endfunction

	function automatic void check_field(string name, logic [MSG_W-1:0] want,
			logic [MSG_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endfunction

	// ---------------- request driver ----------------
	bit req_fire = 1'b0;
	int burst_left = 4;
	int gap_left = 0;

	always @(posedge clk) begin
		req_fire = arst_n && req.valid && req.ready;
		if (req_fire) begin
			pending_results.push_back(apply_request(driven_req));
			n_requests++;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req_fire) begin
			if (gap_left > 0) begin
				req.valid <= 1'b0;
				gap_left--;
			end else if (queued_requests.size() != 0 && queued_requests[0].drain) begin
				req.valid <= 1'b0;
				if (pending_results.size() == 0)
					void'(queued_requests.pop_front());
			end else if (queued_requests.size() != 0) begin
				driven_req = queued_requests.pop_front();
				req.valid <= 1'b1;
				req.mode <= driven_req.mode;
				req.msg_low <= driven_req.msg_low;
				req.msg_high <= driven_req.msg_high;
				req.msg_length <= driven_req.msg_length;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 48)
						: $urandom_range(1, 8);
					case ($urandom_range(0, 3))
						0: gap_left = 0;
						1: gap_left = $urandom_range(1, 3);
						2: gap_left = $urandom_range(4, 20);
						default: gap_left = $urandom_range(21, 40);
					endcase
				end
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// ---------------- result side ----------------
	int ready_cycle = 0;
	int ready_style = 0;

	always @(negedge clk) begin
		ready_cycle++;
		if (ready_cycle % 48 == 0)
			ready_style = $urandom_range(0, 3);
		case (ready_style)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= 1'($urandom_range(0, 1));
			2: rsp.ready <= (ready_cycle % 6 == 0);
			default: rsp.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: status %0d", rsp.status);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", MSG_W'(want.status), MSG_W'(rsp.status));
				check_field("out_low", want.out_low, rsp.out_low);
				check_field("out_high", want.out_high, rsp.out_high);
				check_field("out_length", MSG_W'(want.out_length), MSG_W'(rsp.out_length));
			end
		end
	end

	// ---------------- stimulus and end of run ----------------
	initial begin
		int issued;
		int push_pct;
		int seg_len;
		int pick;
		bit drained_mid;

		arst_n = 1'b0;
		req.valid = 1'b0;
		req.mode = MODE_PUSH;
		req.msg_low = '0;
		req.msg_high = '0;
		req.msg_length = '0;
		rsp.ready = 1'b0;

		// directed opening
		add_request(MODE_POP, rand_word(), rand_word(), 5'd31);
		add_request(MODE_PUSH, rand_word(), rand_word(), 5'd0);
		add_request(MODE_PUSH, rand_word(), rand_word(), 5'd17);
		add_request(MODE_PUSH, '1, '1, 5'd31);
		add_request(MODE_PUSH, '1, '1, 5'd1);
		add_request(MODE_PUSH, '1, '1, 5'd16);
		add_request(MODE_PUSH, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd9);
		repeat (3) add_request(MODE_POP, rand_word(), rand_word(), 5'd0);
		add_request(MODE_POP, '1, '1, 5'd31);
		add_request(MODE_UNUSED, rand_word(), rand_word(), 5'd16);
		add_request(MODE_PUSH, rand_word(), rand_word(), 5'd5);
		add_request(MODE_CLEAR, rand_word(), rand_word(), 5'd5);
		add_request(MODE_POP, rand_word(), rand_word(), 5'd0);
		// three full-size messages use 51 bytes; the fourth has to flush
		repeat (4) add_request(MODE_PUSH, rand_word(), rand_word(), 5'd16);
		add_request(MODE_POP, rand_word(), rand_word(), 5'd0);
		add_request(MODE_POP, rand_word(), rand_word(), 5'd0);
		add_request(MODE_PUSH, '0, '0, 5'd16);
		add_request(MODE_POP, '0, '0, 5'd0);
		add_drain();

		// random phases, each biased toward filling, balanced or biased toward draining
		issued = 0;
		drained_mid = 1'b0;
		while (issued < RANDOM_REQS) begin
			case ($urandom_range(0, 2))
				0: push_pct = 85;
				1: push_pct = 55;
				default: push_pct = 25;
			endcase
			seg_len = $urandom_range(15, 40);
			for (int k = 0; k < seg_len && issued < RANDOM_REQS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 2)
					add_request(MODE_CLEAR, rand_word(), rand_word(), LEN_W'($urandom()));
				else if (pick < 4)
					add_request(MODE_UNUSED, rand_word(), rand_word(), LEN_W'($urandom()));
				else if (pick < push_pct)
					add_request(MODE_PUSH, rand_word(), rand_word(), rand_push_length());
				else
					add_request(MODE_POP, rand_word(), rand_word(), LEN_W'($urandom()));
				issued++;
			end
			if (!drained_mid && issued >= RANDOM_REQS / 2) begin
				add_drain();
				drained_mid = 1'b1;
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (queued_requests.size() != 0 || req.valid || pending_results.size() != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);

		$display("%0d requests: %0d pushes stored, %0d after a flush, %0d dropped,",
			n_requests, n_stored, n_flushed, n_dropped);
		$display("%0d bad lengths; %0d pops returned data, %0d found the queue empty,",
			n_bad_len, n_popped, n_empty);
		$display("%0d bad stored; %0d clears, %0d unused mode",
			n_bad_stored, n_clears, n_unused);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout: %0d results still outstanding", pending_results.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
